// ----- design/button_click_detector_top_assert.svh -----
// Assertion macros for the click detector.
// BCD_ASSERT_IMP checks an overlapping implication and BCD_ASSERT_NXT a
// next-cycle implication. Both are sampled on clk and are off during reset.
`ifndef BUTTON_CLICK_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_CLICK_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define BCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BCD_ASSERT_IMP(label, ante, cons, msg)

`define BCD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- design/bcd_pkg.sv -----
package bcd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 2'd3;

  // Register values after reset.
  localparam logic        ACTIVE_LEVEL_RST   = 1'b0;
  localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd3;
  localparam logic [15:0] SHORT_TICKS_RST    = 16'd300;
  localparam logic [15:0] LONG_TICKS_RST     = 16'd1000;

  localparam logic [7:0] BOUNCE_MAX  = 8'd255;
  localparam logic [3:0] REPEAT_MAX  = 4'd15;
  localparam logic [3:0] REPEAT_ONE  = 4'd1;
  localparam logic [3:0] REPEAT_TWO  = 4'd2;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DOWN       = 3'd1,
    EV_UP         = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6
  } ev_t;

endpackage

// ----- design/button_click_detector_top.sv -----
// Click and long-press detector for one key.
//
// Input channel (in_valid/in_ready): each transaction carries one sampled
// key level, in_raw_level, and stands for one tick. The level is debounced,
// then a small state machine reports press down, press up, single click,
// double click, long-press start and long-press hold.
// Result channel (out_valid/out_ready): exactly one transaction per input
// transaction, carrying the held event code, the latched click event and
// the debounced key level after that tick.
// A tick accepted at one edge is in the result register right after that
// edge. One tick is accepted every cycle unless the receiver stalls; the
// whole tick update (counters, compares and state machine) is one level
// of logic between the state registers and the result register.
// When the receiver stalls, the result register holds its transaction and
// in_ready drops until that result is taken; in_ready is high whenever the
// result register is empty or being emptied in the same cycle.
// Synchronous active-low reset returns the machine to idle, clears all
// counters and events, empties the result register and loads the register
// defaults (active level 0, debounce 3, short 300, long 1000 ticks).
`include "button_click_detector_top_assert.svh"

module button_click_detector_top
  import bcd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_raw_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_event_code,
  output logic [2:0]            out_latched_click,
  output logic                  out_clean_level
);

  // The tick counter is compared against 16-bit thresholds, so both sides
  // are widened to the larger of the two widths.
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] TICK_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_PRESSED  = 3'd1,
    S_RELEASED = 3'd2,
    S_PRESSED2 = 3'd3,
    S_LONG     = 3'd5
  } state_t;

  // Configuration registers.
  logic        active_level_r;
  logic [7:0]  debounce_ticks_r;
  logic [15:0] short_ticks_r;
  logic [15:0] long_ticks_r;

  // Detector state.
  state_t                 state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic                   stable_r, stable_nxt;
  logic [7:0]             bounce_r, bounce_nxt;
  logic [3:0]             repeats_r, repeats_nxt;
  ev_t                    event_r, event_nxt;
  ev_t                    latched_r, latched_nxt;

  // Result register.
  logic       out_valid_r;
  logic [2:0] out_event_r;
  logic [2:0] out_latched_r;
  logic       out_level_r;

  logic                   in_fire;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [7:0]             bounce_inc;
  logic                   pressed;
  logic [CMP_W-1:0]       tick_cmp;
  logic [CMP_W-1:0]       short_cmp;
  logic [CMP_W-1:0]       long_cmp;

  // A new tick may enter whenever the result register is free this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r   <= ACTIVE_LEVEL_RST;
      debounce_ticks_r <= DEBOUNCE_TICKS_RST;
      short_ticks_r    <= SHORT_TICKS_RST;
      long_ticks_r     <= LONG_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL:   active_level_r   <= cfg_wdata[0];
        REG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata[7:0];
        REG_SHORT_TICKS:    short_ticks_r    <= cfg_wdata[15:0];
        REG_LONG_TICKS:     long_ticks_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // The tick counter runs only outside idle and sticks at its maximum.
    tick_inc = tick_r;
    if (state_r != S_IDLE && tick_r != TICK_MAX) begin
      tick_inc = tick_r + 1'b1;
    end

    // Debounce: a differing level is taken once the saturating bounce
    // count has reached the configured number of ticks. A setting of zero
    // therefore behaves like one.
    bounce_inc = (bounce_r != BOUNCE_MAX) ? bounce_r + 8'd1 : bounce_r;
    stable_nxt = stable_r;
    bounce_nxt = 8'd0;
    if (in_raw_level != stable_r) begin
      if (bounce_inc >= debounce_ticks_r) begin
        stable_nxt = in_raw_level;
      end else begin
        bounce_nxt = bounce_inc;
      end
    end

    pressed   = (stable_nxt == active_level_r);
    tick_cmp  = CMP_W'(tick_inc);
    short_cmp = CMP_W'(short_ticks_r);
    long_cmp  = CMP_W'(long_ticks_r);

    state_nxt   = state_r;
    tick_nxt    = tick_inc;
    repeats_nxt = repeats_r;
    event_nxt   = event_r;
    latched_nxt = latched_r;

    case (state_r)
      S_IDLE: begin
        if (pressed) begin
          event_nxt   = EV_DOWN;
          tick_nxt    = '0;
          repeats_nxt = REPEAT_ONE;
          state_nxt   = S_PRESSED;
        end else begin
          event_nxt   = EV_NONE;
          latched_nxt = EV_NONE;
        end
      end
      S_PRESSED: begin
        if (!pressed) begin
          event_nxt   = EV_UP;
          tick_nxt    = '0;
          repeats_nxt = REPEAT_ONE;
          state_nxt   = S_RELEASED;
        end else if (tick_cmp > long_cmp) begin
          event_nxt   = EV_LONG_START;
          latched_nxt = EV_LONG_START;
          state_nxt   = S_LONG;
        end
      end
      S_RELEASED: begin
        if (pressed) begin
          event_nxt = EV_DOWN;
          if (repeats_r != REPEAT_MAX) begin
            repeats_nxt = repeats_r + 4'd1;
          end
          tick_nxt  = '0;
          state_nxt = S_PRESSED2;
        end else if (tick_cmp > short_cmp) begin
          // More than two clicks in a row reports nothing.
          if (repeats_r == REPEAT_ONE) begin
            event_nxt   = EV_SINGLE;
            latched_nxt = EV_SINGLE;
          end else if (repeats_r == REPEAT_TWO) begin
            event_nxt   = EV_DOUBLE;
            latched_nxt = EV_DOUBLE;
          end
          state_nxt = S_IDLE;
        end
      end
      S_PRESSED2: begin
        if (!pressed) begin
          event_nxt = EV_UP;
          if (tick_cmp < short_cmp) begin
            tick_nxt  = '0;
            state_nxt = S_RELEASED;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LONG: begin
        if (pressed) begin
          event_nxt = EV_LONG_HOLD;
        end else begin
          event_nxt = EV_UP;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      stable_r    <= 1'b0;
      bounce_r    <= 8'd0;
      repeats_r   <= 4'd0;
      event_r     <= EV_NONE;
      latched_r   <= EV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        tick_r      <= tick_nxt;
        stable_r    <= stable_nxt;
        bounce_r    <= bounce_nxt;
        repeats_r   <= repeats_nxt;
        event_r     <= event_nxt;
        latched_r   <= latched_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event_r   <= event_nxt;
      out_latched_r <= latched_nxt;
      out_level_r   <= stable_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_event_r;
  assign out_latched_click = out_latched_r;
  assign out_clean_level   = out_level_r;

  // Every accepted tick leaves a result waiting at the next edge.
  `BCD_ASSERT_NXT(a_fire_gives_result, in_fire, out_valid, "accepted tick gave no result")

  // The latched event only ever holds none, single, double or long start.
  `BCD_ASSERT_IMP(a_latched_codes, out_valid, (out_latched_click == EV_NONE) || (out_latched_click == EV_SINGLE) || (out_latched_click == EV_DOUBLE) || (out_latched_click == EV_LONG_START), "latched event out of range")

  // While in long hold, the latched event is the long-press start.
  `BCD_ASSERT_IMP(a_long_latched, state_r == S_LONG, latched_r == EV_LONG_START, "long hold without long start latched")

  // The machine never leaves idle without reporting a press down.
  `BCD_ASSERT_NXT(a_idle_exit_down, in_fire && (state_r == S_IDLE) && (state_nxt != S_IDLE), event_r == EV_DOWN, "idle exit without press down")

endmodule
